@@ rtl/core/rau_pkg.sv @@
// Shared types, constants and helper functions of the rational arithmetic unit.
package rau_pkg;

  localparam int WORD_BITS  = 32;
  localparam int FIELD_BITS = 32;
  localparam int CNT_W      = $clog2(WORD_BITS + 1);

  typedef logic [WORD_BITS-1:0]  word_t;
  typedef logic [FIELD_BITS-1:0] field_t;

  typedef enum logic [3:0] {
    OP_ADD = 4'd0,
    OP_SUB = 4'd1,
    OP_MUL = 4'd2,
    OP_DIV = 4'd3,
    OP_EQ  = 4'd4,
    OP_NE  = 4'd5,
    OP_LT  = 4'd6,
    OP_GT  = 4'd7,
    OP_LE  = 4'd8,
    OP_GE  = 4'd9,
    OP_NEG = 4'd10,
    OP_INC = 4'd11,
    OP_DEC = 4'd12
  } op_t;

  typedef enum logic [2:0] {
    MS_L  = 3'd0,
    MS_R  = 3'd1,
    MS_NN = 3'd2,
    MS_DD = 3'd3,
    MS_DN = 3'd4
  } mul_sel_t;

  typedef enum logic [1:0] {
    DS_GCD = 2'd0,
    DS_NUM = 2'd1,
    DS_DEN = 2'd2
  } div_sel_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_MUL,
    S_FORM,
    S_GTEST,
    S_GSTART,
    S_GWAIT,
    S_QNSTART,
    S_QNWAIT,
    S_QDSTART,
    S_QDWAIT,
    S_FINISH
  } state_t;

  typedef struct packed {
    logic     load;
    logic     mul_en;
    mul_sel_t mul_sel;
    logic     form;
    logic     div_start;
    div_sel_t div_sel;
    logic     gcd_upd;
    logic     qn_upd;
    logic     qd_upd;
    logic     zero_set;
    logic     out_load;
  } rau_cmd_t;

  typedef struct packed {
    logic y_zero;
    logic x_zero;
    logic reduce;
    logic div_done;
    logic out_free;
  } rau_stat_t;

  function automatic word_t to_word(field_t v);
    logic [63:0] e;
    e = {{(64-FIELD_BITS){v[FIELD_BITS-1]}}, v};
    return e[WORD_BITS-1:0];
  endfunction

  function automatic field_t to_field(word_t v);
    logic [63+WORD_BITS:0] e;
    e = {{64{v[WORD_BITS-1]}}, v};
    return e[FIELD_BITS-1:0];
  endfunction

endpackage

@@ rtl/core/rational_arithmetic_unit.sv @@
// Top level of the rational arithmetic unit: controller plus datapath.
// An item takes five multiplies through one shared 32x32 multiplier, then
// Euclid's gcd with one remainder per step through a shared bit-serial divider,
// and for a reduced result two more divides by the gcd through the same divider;
// comparisons and negate skip the gcd and the divides.
// The result sits in an output register, so a new item may enter while it waits.
module rational_arithmetic_unit (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  logic [3:0]           op,
  input  logic signed [rau_pkg::FIELD_BITS-1:0] a_num,
  input  logic signed [rau_pkg::FIELD_BITS-1:0] a_den,
  input  logic signed [rau_pkg::FIELD_BITS-1:0] b_num,
  input  logic signed [rau_pkg::FIELD_BITS-1:0] b_den,
  output logic                 out_valid,
  input  logic                 out_stall,
  output logic signed [rau_pkg::FIELD_BITS-1:0] res_num,
  output logic signed [rau_pkg::FIELD_BITS-1:0] res_den,
  output logic                 cmp_true,
  output logic                 zero_gcd
);
  import rau_pkg::*;

  rau_cmd_t  cmd;
  rau_stat_t stat;

  rau_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .stat     (stat),
    .cmd      (cmd)
  );

  rau_dp u_dp (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .stat      (stat),
    .op        (op),
    .a_num     (a_num),
    .a_den     (a_den),
    .b_num     (b_num),
    .b_den     (b_den),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .res_num   (res_num),
    .res_den   (res_den),
    .cmp_true  (cmp_true),
    .zero_gcd  (zero_gcd)
  );

endmodule

@@ rtl/core/rau_div.sv @@
// Iterative signed divider with truncated quotient and remainder, one bit per cycle.
module rau_div (
  input  logic          clk,
  input  logic          rst,
  input  logic          start,
  input  rau_pkg::word_t dividend,
  input  rau_pkg::word_t divisor,
  output logic          done,
  output rau_pkg::word_t quot,
  output rau_pkg::word_t rem
);
  import rau_pkg::*;

  logic             busy;
  logic [CNT_W-1:0] cnt;
  word_t            racc;
  word_t            qsh;
  word_t            dmag;
  logic             neg_x;
  logic             neg_q;
  logic [WORD_BITS:0] shv;
  logic [WORD_BITS:0] diff;
  logic               take;

  assign shv  = {racc, qsh[WORD_BITS-1]};
  assign diff = shv - {1'b0, dmag};
  assign take = (shv >= {1'b0, dmag});

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= CNT_W'(WORD_BITS);
      end else if (busy) begin
        if (cnt == CNT_W'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
        cnt <= cnt - CNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      racc  <= '0;
      qsh   <= dividend[WORD_BITS-1] ? (~dividend + 1'b1) : dividend;
      dmag  <= divisor[WORD_BITS-1] ? (~divisor + 1'b1) : divisor;
      neg_x <= dividend[WORD_BITS-1];
      neg_q <= dividend[WORD_BITS-1] ^ divisor[WORD_BITS-1];
    end else if (busy) begin
      racc <= take ? diff[WORD_BITS-1:0] : shv[WORD_BITS-1:0];
      qsh  <= {qsh[WORD_BITS-2:0], take};
    end
  end

  assign quot = neg_q ? (~qsh + 1'b1) : qsh;
  assign rem  = neg_x ? (~racc + 1'b1) : racc;

endmodule

@@ rtl/core/rau_dp.sv @@
// Datapath: operand registers, shared multiplier, gcd registers, divider and output register.
module rau_dp (
  input  logic                 clk,
  input  logic                 rst,
  input  rau_pkg::rau_cmd_t    cmd,
  output rau_pkg::rau_stat_t   stat,
  input  logic [3:0]           op,
  input  rau_pkg::field_t      a_num,
  input  rau_pkg::field_t      a_den,
  input  rau_pkg::field_t      b_num,
  input  rau_pkg::field_t      b_den,
  output logic                 out_valid,
  input  logic                 out_stall,
  output logic signed [rau_pkg::FIELD_BITS-1:0] res_num,
  output logic signed [rau_pkg::FIELD_BITS-1:0] res_den,
  output logic                 cmp_true,
  output logic                 zero_gcd
);
  import rau_pkg::*;

  op_t   op_r;
  word_t an, ad, bn, bd;
  word_t pl, pr, pnn, pdd, pdn;
  word_t mul_a, mul_b;
  word_t prod;
  word_t num_r, den_r, x, y;
  logic  cmp_r, red_r, zg_r;
  word_t num_c, den_c;
  logic  cmp_c, red_c;
  word_t div_n, div_d, quot, rem;
  logic  div_done;

  always_comb begin
    mul_a = an;
    mul_b = bd;
    case (cmd.mul_sel)
      MS_L:  begin mul_a = an; mul_b = bd; end
      MS_R:  begin mul_a = bn; mul_b = ad; end
      MS_NN: begin mul_a = an; mul_b = bn; end
      MS_DD: begin mul_a = ad; mul_b = bd; end
      MS_DN: begin mul_a = ad; mul_b = bn; end
      default: begin mul_a = an; mul_b = bd; end
    endcase
  end

  // Only the low word of each product is kept, so products wrap.
  assign prod = mul_a * mul_b;

  always_comb begin
    num_c = '0;
    den_c = '0;
    cmp_c = 1'b0;
    red_c = 1'b0;
    case (op_r)
      OP_ADD: begin num_c = pl + pr; den_c = pdd; red_c = 1'b1; end
      OP_SUB: begin num_c = pl - pr; den_c = pdd; red_c = 1'b1; end
      OP_MUL: begin num_c = pnn; den_c = pdd; red_c = 1'b1; end
      OP_DIV: begin num_c = pl; den_c = pdn; red_c = 1'b1; end
      OP_EQ:  cmp_c = (pl == pr);
      OP_NE:  cmp_c = (pl != pr);
      OP_LT:  cmp_c = ($signed(pl) < $signed(pr));
      OP_GT:  cmp_c = ($signed(pr) < $signed(pl));
      OP_LE:  cmp_c = !($signed(pr) < $signed(pl));
      OP_GE:  cmp_c = !($signed(pl) < $signed(pr));
      OP_NEG: begin num_c = ~an + 1'b1; den_c = ad; end
      OP_INC: begin num_c = an + ad; den_c = ad; red_c = 1'b1; end
      OP_DEC: begin num_c = an - ad; den_c = ad; red_c = 1'b1; end
      default: ;
    endcase
  end

  always_comb begin
    div_n = x;
    div_d = y;
    case (cmd.div_sel)
      DS_GCD: begin div_n = x;     div_d = y; end
      DS_NUM: begin div_n = num_r; div_d = x; end
      DS_DEN: begin div_n = den_r; div_d = x; end
      default: begin div_n = x;    div_d = y; end
    endcase
  end

  rau_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (cmd.div_start),
    .dividend (div_n),
    .divisor  (div_d),
    .done     (div_done),
    .quot     (quot),
    .rem      (rem)
  );

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      op_r <= op_t'(op);
      an   <= to_word(a_num);
      ad   <= to_word(a_den);
      bn   <= to_word(b_num);
      bd   <= to_word(b_den);
    end
    if (cmd.mul_en) begin
      case (cmd.mul_sel)
        MS_L:  pl  <= prod;
        MS_R:  pr  <= prod;
        MS_NN: pnn <= prod;
        MS_DD: pdd <= prod;
        MS_DN: pdn <= prod;
        default: ;
      endcase
    end
    if (cmd.form) begin
      num_r <= num_c;
      den_r <= den_c;
      cmp_r <= cmp_c;
      red_r <= red_c;
      zg_r  <= 1'b0;
      x     <= num_c;
      y     <= den_c;
    end
    if (cmd.gcd_upd) begin
      x <= y;
      y <= rem;
    end
    if (cmd.qn_upd) num_r <= quot;
    if (cmd.qd_upd) den_r <= quot;
    if (cmd.zero_set) begin
      num_r <= '0;
      den_r <= '0;
      zg_r  <= 1'b1;
    end
    if (cmd.out_load) begin
      res_num  <= to_field(num_r);
      res_den  <= to_field(den_r);
      cmp_true <= cmp_r;
      zero_gcd <= zg_r;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  assign stat.y_zero   = (y == '0);
  assign stat.x_zero   = (x == '0);
  assign stat.reduce   = red_r;
  assign stat.div_done = div_done;
  assign stat.out_free = !out_valid || !out_stall;

endmodule

@@ rtl/core/rau_ctrl.sv @@
// Controller state machine that sequences multiplies, the gcd loop and the final divides.
module rau_ctrl (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_stall,
  input  rau_pkg::rau_stat_t  stat,
  output rau_pkg::rau_cmd_t   cmd
);
  import rau_pkg::*;

  state_t   state, state_next;
  mul_sel_t msel, msel_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      msel  <= MS_L;
    end else begin
      state <= state_next;
      msel  <= msel_next;
    end
  end

  always_comb begin
    state_next  = state;
    msel_next   = msel;
    cmd         = '0;
    cmd.mul_sel = msel;
    cmd.div_sel = DS_GCD;
    in_stall    = 1'b1;
    unique case (state)
      S_IDLE: begin
        in_stall = 1'b0;
        if (in_valid) begin
          cmd.load   = 1'b1;
          msel_next  = MS_L;
          state_next = S_MUL;
        end
      end
      S_MUL: begin
        cmd.mul_en = 1'b1;
        if (msel == MS_DN) begin
          state_next = S_FORM;
        end else begin
          msel_next = mul_sel_t'(msel + 3'd1);
        end
      end
      S_FORM: begin
        cmd.form   = 1'b1;
        state_next = S_GTEST;
      end
      S_GTEST: begin
        if (!stat.reduce) begin
          state_next = S_FINISH;
        end else if (!stat.y_zero) begin
          state_next = S_GSTART;
        end else if (stat.x_zero) begin
          // Numerator and denominator both zero: no reduction possible.
          cmd.zero_set = 1'b1;
          state_next   = S_FINISH;
        end else begin
          state_next = S_QNSTART;
        end
      end
      S_GSTART: begin
        cmd.div_start = 1'b1;
        state_next    = S_GWAIT;
      end
      S_GWAIT: begin
        if (stat.div_done) begin
          cmd.gcd_upd = 1'b1;
          state_next  = S_GTEST;
        end
      end
      S_QNSTART: begin
        cmd.div_sel   = DS_NUM;
        cmd.div_start = 1'b1;
        state_next    = S_QNWAIT;
      end
      S_QNWAIT: begin
        if (stat.div_done) begin
          cmd.qn_upd = 1'b1;
          state_next = S_QDSTART;
        end
      end
      S_QDSTART: begin
        cmd.div_sel   = DS_DEN;
        cmd.div_start = 1'b1;
        state_next    = S_QDWAIT;
      end
      S_QDWAIT: begin
        if (stat.div_done) begin
          cmd.qd_upd = 1'b1;
          state_next = S_FINISH;
        end
      end
      S_FINISH: begin
        if (stat.out_free) begin
          cmd.out_load = 1'b1;
          state_next   = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

endmodule

@@ rtl/core/rau_checker.sv @@
// Port-level checker for the rational arithmetic unit and its bind.
module rau_checker (
  input logic        clk,
  input logic        rst,
  input logic        in_valid,
  input logic        in_stall,
  input logic        out_valid,
  input logic        out_stall,
  input logic [31:0] res_num,
  input logic [31:0] res_den,
  input logic        cmp_true,
  input logic        zero_gcd
);

  // An accepted item keeps the input side busy in the following cycle.
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall |=> in_stall)
    else $error("input not stalled after an accepted item");

  a_zero_gcd_result: assert property (@(posedge clk) disable iff (rst)
    out_valid && zero_gcd |-> res_num == 32'd0 && res_den == 32'd0 && !cmp_true)
    else $error("zero gcd item without a 0/0 result");

  a_cmp_result: assert property (@(posedge clk) disable iff (rst)
    out_valid && cmp_true |-> res_num == 32'd0 && res_den == 32'd0 && !zero_gcd)
    else $error("comparison item with a nonzero fraction");

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(res_num) && $stable(res_den))
    else $error("stalled result item changed");

endmodule

bind rational_arithmetic_unit rau_checker u_rau_checker (
  .clk       (clk),
  .rst       (rst),
  .in_valid  (in_valid),
  .in_stall  (in_stall),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .res_num   (res_num),
  .res_den   (res_den),
  .cmp_true  (cmp_true),
  .zero_gcd  (zero_gcd)
);

@@ tb/sv/rational_arithmetic_unit_tb.sv @@
// Self-checking testbench of the rational arithmetic unit with a fraction predictor.
module rational_arithmetic_unit_tb;
  import rau_pkg::*;

  typedef struct {
    logic [31:0] num;
    logic [31:0] den;
    logic        cmp;
    logic        zg;
  } frac_res_t;

  // Holds the predicted fractions in order and checks each one that arrives.
  class frac_board;
    frac_res_t pending[$];
    int errors;

    function automatic logic [31:0] trem(logic [31:0] x, logic [31:0] y);
      logic [31:0] mx, my, r;
      mx = x[31] ? -x : x;
      my = y[31] ? -y : y;
      r = mx % my;
      return x[31] ? -r : r;
    endfunction

    function automatic logic [31:0] tdiv(logic [31:0] x, logic [31:0] y);
      logic [31:0] mx, my, q;
      mx = x[31] ? -x : x;
      my = y[31] ? -y : y;
      q = mx / my;
      return (x[31] != y[31]) ? -q : q;
    endfunction

    function automatic void note_item(logic [3:0] o, logic [31:0] an, logic [31:0] ad,
                                      logic [31:0] bn, logic [31:0] bd);
      frac_res_t e;
      logic [31:0] l, r, x, y, t;
      logic red;
      e = '{0, 0, 0, 0};
      red = 0;
      l = an * bd;
      r = bn * ad;
      case (o)
        OP_ADD: begin e.num = l + r; e.den = ad * bd; red = 1; end
        OP_SUB: begin e.num = l - r; e.den = ad * bd; red = 1; end
        OP_MUL: begin e.num = an * bn; e.den = ad * bd; red = 1; end
        OP_DIV: begin e.num = l; e.den = ad * bn; red = 1; end
        OP_EQ: e.cmp = (l == r);
        OP_NE: e.cmp = (l != r);
        OP_LT: e.cmp = $signed(l) < $signed(r);
        OP_GT: e.cmp = $signed(r) < $signed(l);
        OP_LE: e.cmp = !($signed(r) < $signed(l));
        OP_GE: e.cmp = !($signed(l) < $signed(r));
        OP_NEG: begin e.num = -an; e.den = ad; end
        OP_INC: begin e.num = an + ad; e.den = ad; red = 1; end
        OP_DEC: begin e.num = an - ad; e.den = ad; red = 1; end
        default: ;
      endcase
      if (red) begin
        x = e.num;
        y = e.den;
        while (y != 0) begin
          t = trem(x, y);
          x = y;
          y = t;
        end
        if (x == 0) begin
          e.zg = 1; e.num = 0; e.den = 0;
        end else begin
          e.num = tdiv(e.num, x);
          e.den = tdiv(e.den, x);
        end
      end
      pending.push_back(e);
    endfunction

    function automatic void check(logic [31:0] n, logic [31:0] d, logic c, logic z);
      frac_res_t e;
      if (pending.size() == 0) begin
        $error("unexpected result %h/%h", n, d);
        errors++;
        return;
      end
      e = pending.pop_front();
      if (n !== e.num) begin $error("res_num exp %h got %h", e.num, n); errors++; end
      if (d !== e.den) begin $error("res_den exp %h got %h", e.den, d); errors++; end
      if (c !== e.cmp) begin $error("cmp_true exp %b got %b", e.cmp, c); errors++; end
      if (z !== e.zg) begin $error("zero_gcd exp %b got %b", e.zg, z); errors++; end
    endfunction
  endclass

  logic clk = 0, rst = 1;
  logic in_valid = 0, in_stall, out_valid, out_stall = 0;
  logic [3:0] op = 0;
  logic signed [31:0] a_num = 0, a_den = 0, b_num = 0, b_den = 0;
  logic signed [31:0] res_num, res_den;
  logic cmp_true, zero_gcd;
  frac_board board = new();
  int cycles = 0;
  bit calm = 0;

  localparam int CYCLE_LIMIT = 12_000_000;

  rational_arithmetic_unit dut (.*);

  always begin
    #5 clk = 1;
    #5 clk = 0;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("CHECKS FAILED");
      $finish;
    end
  end

  always @(posedge clk)
    if (!rst && out_valid && !out_stall)
      board.check(res_num, res_den, cmp_true, zero_gcd);

  // Receiver stalls come in random bursts until the calm tail of the run.
  initial begin
    int n;
    forever begin
      @(posedge clk);
      if (!calm && $urandom_range(0, 5) == 0) begin
        n = $urandom_range(1, 16);
        out_stall <= 1;
        repeat (n) @(posedge clk);
        out_stall <= 0;
      end
    end
  end

  function automatic logic [31:0] pick_word();
    case ($urandom_range(0, 7))
      0: return 32'h8000_0000;
      1: return 32'h7fff_ffff;
      2: return 0;
      3: return $urandom_range(0, 3) - 1;
      4, 5: return $signed($urandom_range(0, 40)) - 20;
      6: return $signed($urandom_range(0, 2000)) - 1000;
      default: return $urandom;
    endcase
  endfunction

  task automatic send(logic [3:0] o, logic [31:0] an, logic [31:0] ad,
                      logic [31:0] bn, logic [31:0] bd);
    op <= o; a_num <= an; a_den <= ad; b_num <= bn; b_den <= bd;
    in_valid <= 1;
    do @(posedge clk); while (in_stall);
    board.note_item(o, an, ad, bn, bd);
  endtask

  task automatic gap();
    if (!calm && $urandom_range(0, 4) == 0) begin
      in_valid <= 0;
      repeat ($urandom_range(1, 16)) @(posedge clk);
    end
  endtask

  task automatic drain();
    in_valid <= 0;
    while (board.pending.size() != 0) @(posedge clk);
  endtask

  initial begin
    logic [3:0] o;
    repeat (12) @(posedge clk);
    rst <= 0;
    @(posedge clk);
    for (int k = 0; k <= 12; k++) send(4'(k), 3, 4, -5, 6);
    send(4'd13, 1, 2, 3, 4);
    send(4'd15, 32'hffff_ffff, 32'hffff_ffff, 32'hffff_ffff, 32'hffff_ffff);
    send(OP_ADD, 0, 0, 0, 0);
    send(OP_MUL, 32'h8000_0000, 1, -1, 1);
    send(OP_DIV, 32'h8000_0000, -1, 1, 32'h8000_0000);
    send(OP_SUB, 32'h7fff_ffff, 32'h7fff_ffff, 32'h8000_0000, 32'h7fff_ffff);
    send(OP_NEG, 32'h8000_0000, 0, 0, 0);
    send(OP_INC, 32'h7fff_ffff, 1, 0, 0);
    send(OP_DEC, 32'h8000_0000, 1, 0, 0);
    send(OP_LT, 32'h7fff_ffff, 2, 1, 1);
    send(OP_EQ, 0, 0, 0, 0);
    drain();
    @(posedge clk);
    for (int i = 0; i < 1750; i++) begin
      if (i == 1600) calm = 1;
      if (i == 800) begin
        drain();
        @(posedge clk);
      end
      o = ($urandom_range(0, 19) == 0) ? 4'($urandom_range(13, 15))
                                       : 4'($urandom_range(0, 12));
      send(o, pick_word(), pick_word(), pick_word(), pick_word());
      gap();
    end
    drain();
    repeat (50) @(posedge clk);
    if (board.errors == 0 && board.pending.size() == 0)
      $display("ALL CHECKS PASSED");
    else
      $display("CHECKS FAILED");
    $finish;
  end
endmodule
